// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, masked while reset is asserted
`define SGRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgrm assertion failed");

// implication checked in the next cycle, masked while reset is asserted
`define SGRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgrm assertion failed");

// implication checked in the next cycle, also active through reset
`define SGRM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sgrm assertion failed");

`endif

// ===== hdl/sgrm_pkg.sv =====
// shared types and constants for the sgr mouse report parser
`default_nettype none

package sgrm_pkg;

    localparam int BYTE_W          = 8;
    localparam int POS_W           = 13;
    localparam int EV_W            = 3;
    localparam int COORD_WIDTH_DEF = 12;
    localparam int CODE_W          = 6;
    localparam int OUT_TDATA_W     = 32;

    localparam logic [BYTE_W-1:0] CHR_ESC     = 8'h1B;
    localparam logic [BYTE_W-1:0] CHR_BRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CHR_LT      = 8'h3C;
    localparam logic [BYTE_W-1:0] CHR_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CHR_REL     = 8'h6D;
    localparam logic [BYTE_W-1:0] CHR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE    = 8'h39;

    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd2;
    localparam int         MOTION_BIT = 5;

    localparam logic [EV_W-1:0] EV_LEFT_PRESS   = 3'd0;
    localparam logic [EV_W-1:0] EV_LEFT_RELEASE = 3'd2;
    localparam logic [EV_W-1:0] EV_LEFT_DRAG    = 3'd4;
    localparam logic [EV_W-1:0] EV_POSITION     = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ESC     = 3'd1,
        PH_BRACKET = 3'd2,
        PH_CODE    = 3'd3,
        PH_COL     = 3'd4,
        PH_ROW     = 3'd5
    } phase_t;

    typedef struct packed {
        logic                   valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [EV_W-1:0]        event_code;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/sgrm_in_stage.sv =====
// input byte register with stream handshake
`default_nettype none

module sgrm_in_stage (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [sgrm_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                      take,
    output logic                           byte_valid,
    output logic [sgrm_pkg::BYTE_W-1:0]    byte_data
);
    import sgrm_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // free when empty or when the held byte leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sgrm_parser.sv =====
// report recognizer state machine and result formatting
`default_nettype none

module sgrm_parser #(
    parameter int COORD_WIDTH = sgrm_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step,
    input  wire logic [sgrm_pkg::BYTE_W-1:0] byte_data,
    output sgrm_pkg::result_t                res
);
    import sgrm_pkg::*;

    localparam int MulW = COORD_WIDTH + 4;
    localparam int ExtW = (COORD_WIDTH + 1 > POS_W) ? COORD_WIDTH + 1 : POS_W;
    localparam logic [COORD_WIDTH-1:0] CoordMax = {COORD_WIDTH{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic                   digit_reg, digit_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic [COORD_WIDTH-1:0] col_reg, col_next;
    logic [COORD_WIDTH-1:0] row_reg, row_next;

    logic                   is_digit;
    logic [3:0]             dval;
    logic [MulW-1:0]        col_mul, row_mul;
    logic [COORD_WIDTH-1:0] col_sat, row_sat;
    logic [CODE_W-1:0]      code_mul;
    logic [ExtW-1:0]        col_ext, row_ext;
    logic [1:0]             button;
    logic [EV_W-1:0]        side;
    logic [EV_W-1:0]        ev;

    assign is_digit = (byte_data >= CHR_ZERO) && (byte_data <= CHR_NINE);
    assign dval     = is_digit ? 4'(byte_data - CHR_ZERO) : 4'd0;

    // times ten as shift and add; coordinates saturate, the code keeps its low bits
    assign col_mul = (MulW'(col_reg) << 3) + (MulW'(col_reg) << 1) + MulW'(dval);
    assign row_mul = (MulW'(row_reg) << 3) + (MulW'(row_reg) << 1) + MulW'(dval);
    assign col_sat = (col_mul > MulW'(CoordMax)) ? CoordMax : col_mul[COORD_WIDTH-1:0];
    assign row_sat = (row_mul > MulW'(CoordMax)) ? CoordMax : row_mul[COORD_WIDTH-1:0];
    assign code_mul = CODE_W'({code_reg, 3'b000}) + CODE_W'({code_reg, 1'b0})
                    + CODE_W'(dval);

    // zero-based position, wraps to all ones for a zero coordinate
    assign col_ext = ExtW'(col_reg) - ExtW'(1);
    assign row_ext = ExtW'(row_reg) - ExtW'(1);

    assign button = code_reg[1:0];
    assign side   = (button == BTN_RIGHT) ? 3'd1 : 3'd0;

    always_comb begin
        ev = EV_POSITION;
        if (button == BTN_LEFT || button == BTN_RIGHT) begin
            if (byte_data == CHR_REL) begin
                ev = EV_LEFT_RELEASE + side;
            end else if (code_reg[MOTION_BIT]) begin
                ev = EV_LEFT_DRAG + side;
            end else begin
                ev = EV_LEFT_PRESS + side;
            end
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        digit_next     = digit_reg;
        code_next      = code_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        res.valid      = 1'b0;
        res.pos_x      = col_ext[POS_W-1:0];
        res.pos_y      = row_ext[POS_W-1:0];
        res.event_code = ev;
        unique case (phase_reg)
            PH_ESC: begin
                if (byte_data == CHR_BRACKET) begin
                    phase_next = PH_BRACKET;
                end else begin
                    phase_next = (byte_data == CHR_ESC) ? PH_ESC : PH_IDLE;
                    digit_next = 1'b0;
                end
            end
            PH_BRACKET: begin
                if (byte_data == CHR_LT) begin
                    phase_next = PH_CODE;
                    digit_next = 1'b0;
                    code_next  = '0;
                    col_next   = '0;
                    row_next   = '0;
                end else begin
                    phase_next = (byte_data == CHR_ESC) ? PH_ESC : PH_IDLE;
                    digit_next = 1'b0;
                end
            end
            PH_CODE: begin
                if (is_digit) begin
                    code_next  = code_mul;
                    digit_next = 1'b1;
                end else if (byte_data == CHR_SEMI && digit_reg) begin
                    phase_next = PH_COL;
                    digit_next = 1'b0;
                end else begin
                    phase_next = (byte_data == CHR_ESC) ? PH_ESC : PH_IDLE;
                    digit_next = 1'b0;
                end
            end
            PH_COL: begin
                if (is_digit) begin
                    col_next   = col_sat;
                    digit_next = 1'b1;
                end else if (byte_data == CHR_SEMI && digit_reg) begin
                    phase_next = PH_ROW;
                    digit_next = 1'b0;
                end else begin
                    phase_next = (byte_data == CHR_ESC) ? PH_ESC : PH_IDLE;
                    digit_next = 1'b0;
                end
            end
            PH_ROW: begin
                if (is_digit) begin
                    row_next   = row_sat;
                    digit_next = 1'b1;
                end else begin
                    // any non-digit after row digits terminates the report
                    res.valid  = digit_reg;
                    phase_next = (byte_data == CHR_ESC) ? PH_ESC : PH_IDLE;
                    digit_next = 1'b0;
                end
            end
            default: begin
                phase_next = (byte_data == CHR_ESC) ? PH_ESC : PH_IDLE;
                digit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            digit_reg <= 1'b0;
            code_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
            code_reg  <= code_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sgrm_out_stage.sv =====
// result register driving the master stream
`default_nettype none

module sgrm_out_stage (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             load,
    input  wire sgrm_pkg::result_t                res,
    output logic                                  can_load,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sgrm_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import sgrm_pkg::*;

    localparam int PackW = 2 * POS_W + EV_W;

    logic                   valid_reg, valid_next;
    logic [PackW-1:0]       data_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_W'(data_reg);

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {res.event_code, res.pos_y, res.pos_x};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sgr_mouse_report_parser_top.sv =====
// top level of the xterm sgr mouse report parser
`default_nettype none

// Recognizes xterm SGR mouse reports (ESC [ < code ; column ; row, then any
// non-digit terminator) in a stream of raw terminal bytes, one byte per beat.
// Each complete report yields one result beat with zero-based x and y and an
// event code; bytes that do not complete a report yield nothing. A byte passes
// through the input register, then through the recognizer into the result
// register. A new byte is accepted every cycle as long as the result side keeps
// up; the result register only holds the byte path when a finished report is
// still waiting there. Coordinates saturate at 2^COORD_WIDTH - 1, the button
// code keeps its low six bits, and a mismatched byte drops the partial report
// (ESC restarts it).
module sgr_mouse_report_parser_top #(
    parameter int COORD_WIDTH = sgrm_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // slave side: raw terminal bytes
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sgrm_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] byte_in
    // master side: decoded reports
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [12:0] pos_x, [25:13] pos_y, [28:26] event_code, [31:29] zero
    output logic [sgrm_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import sgrm_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              can_load;
    logic              step;
    result_t           res;

    // a held byte moves on once the result register has room
    assign step = byte_valid && can_load;

    sgrm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sgrm_parser #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_data (byte_data),
        .res       (res)
    );

    // only terminating bytes produce a beat
    sgrm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res.valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/sgrm_checker.sv =====
// port-level checker for the sgr mouse report parser and its bind
`default_nettype none
`include "assert_macros.svh"

module sgrm_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [sgrm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import sgrm_pkg::*;

    // reset empties the result side
    `SGRM_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)
    // a stalled result beat holds
    `SGRM_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // event code seven is never produced and padding stays zero
    `SGRM_ASSERT_NOW(a_event, aclk, aresetn, m_tvalid, m_tdata[28:26] != 3'd7 && m_tdata[31:29] == 3'd0)
    // a fresh result beat traces back through the result and input registers to an input beat
    `SGRM_ASSERT_NOW(a_cause, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind sgr_mouse_report_parser_top sgrm_checker u_sgrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
